// ===== rtl/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear-probing hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

   // table geometry; the home slot is a mask of the key, so keep this a power of two
   localparam int TABLE_SIZE = 16;
   localparam int SLOT_W     = $clog2(TABLE_SIZE);
   localparam int KEY_W      = 31;
   localparam int OUT_SLOT_W = 4;
   localparam int STATUS_W   = 2;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_SEARCH = 1'b1
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_FULL      = 2'd1,
      ST_FOUND     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic {
      CTL_IDLE  = 1'b0,
      CTL_PROBE = 1'b1
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request, set probe pointer to home slot
      logic advance;   // step probe pointer and count
      logic finish;    // commit table write and result beat
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;      // current probe decides the outcome
      logic out_free;  // result register can take a beat this cycle
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/lpht_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpht_ctrl
// Controller: takes one request, walks the probe sequence, hands off result.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire lpht_pkg::sts_type sts,
   output lpht_pkg::cmd_type     cmd
);

   lpht_pkg::ctl_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpht_pkg::CTL_IDLE: begin
            if (req_tvalid) state_in = lpht_pkg::CTL_PROBE;
         end
         lpht_pkg::CTL_PROBE: begin
            if (sts.done && sts.out_free) state_in = lpht_pkg::CTL_IDLE;
         end
         default: state_in = lpht_pkg::CTL_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready  = 1'b0;
      cmd.load    = 1'b0;
      cmd.advance = 1'b0;
      cmd.finish  = 1'b0;
      case (state_ff)
         lpht_pkg::CTL_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         lpht_pkg::CTL_PROBE: begin
            cmd.advance = !sts.done;
            cmd.finish  = sts.done && sts.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpht_pkg::CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lpht_dp.sv =====
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: request registers, probe pointer, slot table and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lpht_pkg::cmd_type                   cmd,
   output lpht_pkg::sts_type                        sts,
   input  wire logic                                req_mode,
   input  wire logic [lpht_pkg::KEY_W-1:0]          req_key,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output lpht_pkg::status_type                     rsp_status,
   output logic [lpht_pkg::OUT_SLOT_W-1:0]          rsp_slot
);

   // request and probe registers
   lpht_pkg::mode_type                 mode_ff;
   logic [lpht_pkg::KEY_W-1:0]         key_ff;
   logic [lpht_pkg::SLOT_W-1:0]        ptr_ff, ptr_in;
   logic [lpht_pkg::SLOT_W-1:0]        cnt_ff;

   // slot table
   logic [lpht_pkg::KEY_W-1:0]         key_mem [lpht_pkg::TABLE_SIZE];
   logic [lpht_pkg::TABLE_SIZE-1:0]    used_ff;

   // result register
   logic                               rsp_valid_ff;
   lpht_pkg::status_type               rsp_status_ff;
   logic [lpht_pkg::OUT_SLOT_W-1:0]    rsp_slot_ff;

   logic                               cur_used;
   logic                               cur_match;
   logic                               cur_last;
   logic                               do_write;
   lpht_pkg::status_type               res_status;
   logic [lpht_pkg::OUT_SLOT_W-1:0]    res_slot;

   // look at the slot under the probe pointer
   assign cur_used  = used_ff[ptr_ff];
   assign cur_match = (key_mem[ptr_ff] == key_ff);
   assign cur_last  = (cnt_ff == lpht_pkg::LAST_SLOT);

   // decide the outcome of this probe
   always_comb begin
      sts.done     = 1'b0;
      sts.out_free = !rsp_valid_ff || rsp_ready;
      do_write     = 1'b0;
      res_status   = lpht_pkg::ST_NOT_FOUND;
      res_slot     = '0;
      if (mode_ff == lpht_pkg::MODE_INSERT) begin
         if (!cur_used) begin
            sts.done   = 1'b1;
            do_write   = 1'b1;
            res_status = lpht_pkg::ST_INSERTED;
            res_slot   = lpht_pkg::OUT_SLOT_W'(ptr_ff);
         end else if (cur_last) begin
            sts.done   = 1'b1;
            res_status = lpht_pkg::ST_FULL;
         end
      end else begin
         if (!cur_used) begin
            sts.done   = 1'b1;
         end else if (cur_match) begin
            sts.done   = 1'b1;
            res_status = lpht_pkg::ST_FOUND;
            res_slot   = lpht_pkg::OUT_SLOT_W'(ptr_ff);
         end else if (cur_last) begin
            sts.done   = 1'b1;
         end
      end
   end

   // next probe position: home slot on load, otherwise step with wraparound
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.load) begin
         ptr_in = lpht_pkg::SLOT_W'(req_key % lpht_pkg::TABLE_SIZE);
      end else if (cmd.advance) begin
         ptr_in = (ptr_ff == lpht_pkg::LAST_SLOT) ? '0 : ptr_ff + 1'b1;
      end
   end

   // request and probe registers
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.load) begin
         mode_ff <= lpht_pkg::mode_type'(req_mode);
         key_ff  <= req_key;
         cnt_ff  <= '0;
      end else if (cmd.advance) begin
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   // key store, written on a successful insert
   always_ff @(posedge clock) begin
      if (cmd.finish && do_write) begin
         key_mem[ptr_ff] <= key_ff;
      end
   end

   // used bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.finish && do_write) begin
         used_ff[ptr_ff] <= 1'b1;
      end
   end

   // result register: hold until taken, load on finish
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= res_status;
         rsp_slot_ff   <= res_slot;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

endmodule

`default_nettype wire

// ===== rtl/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing: insert or search a key.
// ----------------------------------------------------------------------------
// Probing: the request is taken in the idle cycle, then one slot is probed per cycle
// (1 to 16 slots); the deciding probe holds while the previous result still waits
// downstream, and the registered result beat loads when it finishes.
// Requests: one at a time; the next is taken the cycle after the result loads,
// so each item's time is set by the single-slot probe loop and any result stall.
// A new request is taken while the previous result still waits downstream.
// Reset: synchronous, active high; clears all used bits (table empty) at once.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [30:0] key, [31] zero fill
   input  wire logic [0:0]  req_tuser,   // [0] mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // [1:0] status, [5:2] slot, [7:6] zero
);

   lpht_pkg::cmd_type                    cmd;
   lpht_pkg::sts_type                    sts;
   lpht_pkg::status_type                 rsp_status;
   logic [lpht_pkg::OUT_SLOT_W-1:0]      rsp_slot;

   lpht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lpht_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_mode   (req_tuser[0]),
      .req_key    (req_tdata[lpht_pkg::KEY_W-1:0]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot)
   );

   // pack the result beat
   assign rsp_tdata = {2'b00, rsp_slot, rsp_status};

`ifndef SYNTHESIS
   // a miss carries slot zero
   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status == lpht_pkg::ST_FULL ||
                     rsp_status == lpht_pkg::ST_NOT_FOUND) |-> rsp_slot == '0)
      else $error("miss result with nonzero slot");

   // not ready in the cycle after taking a request
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous still probing");

   // a finish never overwrites a result still waiting downstream
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten");

   // load, advance and finish commands are mutually exclusive
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.advance, cmd.finish}))
      else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for linear_probe_hash_table. Directed and random insert and search
// beats go in on the request stream. Results from a local table model queue
// up in order and are checked against each response beat, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_LIMIT   = 400000;
   localparam int DRAIN_WAIT  = 24;
   localparam logic [lpht_pkg::KEY_W-1:0] KEY_MAX = {lpht_pkg::KEY_W{1'b1}};

   typedef struct packed {
      lpht_pkg::status_type                status;
      logic [lpht_pkg::OUT_SLOT_W-1:0]     slot;
   } probe_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;    // [30:0] key, [31] zero fill
   logic [0:0]  req_tuser  = '0;    // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [1:0] status, [5:2] slot, [7:6] zero

   // model of the table contents
   logic [lpht_pkg::KEY_W-1:0] model_keys [lpht_pkg::TABLE_SIZE];
   logic                       model_used [lpht_pkg::TABLE_SIZE];

   probe_result_type pending_results [$];

   int cycle_count    = 0;
   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int inserts_sent   = 0;
   int searches_sent  = 0;
   int status_seen [4];

   linear_probe_hash_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Work out the outcome of one request and update the table model
   function automatic probe_result_type predict_probe(lpht_pkg::mode_type mode,
                                                      logic [lpht_pkg::KEY_W-1:0] key);
      probe_result_type res;
      int               idx;
      idx = int'(key % lpht_pkg::TABLE_SIZE);
      res.slot = '0;
      if (mode == lpht_pkg::MODE_INSERT) begin
         res.status = lpht_pkg::ST_FULL;
         for (int n = 0; n < lpht_pkg::TABLE_SIZE; n++) begin
            if (!model_used[idx]) begin
               model_keys[idx] = key;
               model_used[idx] = 1'b1;
               res.status      = lpht_pkg::ST_INSERTED;
               res.slot        = lpht_pkg::OUT_SLOT_W'(idx);
               break;
            end
            idx = (idx == lpht_pkg::TABLE_SIZE - 1) ? 0 : idx + 1;
         end
      end else begin
         res.status = lpht_pkg::ST_NOT_FOUND;
         for (int n = 0; n < lpht_pkg::TABLE_SIZE; n++) begin
            if (!model_used[idx])
               break;
            if (model_keys[idx] == key) begin
               res.status = lpht_pkg::ST_FOUND;
               res.slot   = lpht_pkg::OUT_SLOT_W'(idx);
               break;
            end
            idx = (idx == lpht_pkg::TABLE_SIZE - 1) ? 0 : idx + 1;
         end
      end
      return res;
   endfunction

   function automatic bit key_stored(logic [lpht_pkg::KEY_W-1:0] key);
      for (int i = 0; i < lpht_pkg::TABLE_SIZE; i++)
         if (model_used[i] && model_keys[i] == key)
            return 1'b1;
      return 1'b0;
   endfunction

   // Pick some key already in the table, or a random one while it is empty
   function automatic logic [lpht_pkg::KEY_W-1:0] any_stored_key();
      int start;
      int idx;
      start = $urandom_range(lpht_pkg::TABLE_SIZE - 1);
      for (int n = 0; n < lpht_pkg::TABLE_SIZE; n++) begin
         idx = (start + n) % lpht_pkg::TABLE_SIZE;
         if (model_used[idx])
            return model_keys[idx];
      end
      return lpht_pkg::KEY_W'($urandom());
   endfunction

   // Same home slot as a stored key, most likely absent from the table
   function automatic logic [lpht_pkg::KEY_W-1:0] colliding_key();
      return any_stored_key() +
             lpht_pkg::KEY_W'(lpht_pkg::TABLE_SIZE * $urandom_range(1, 64));
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Send one request beat; valid stays high afterwards unless a gap follows
   task automatic send_request(lpht_pkg::mode_type mode, logic [lpht_pkg::KEY_W-1:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, key};
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_results.push_back(predict_probe(mode, key));
      if (mode == lpht_pkg::MODE_INSERT)
         inserts_sent++;
      else
         searches_sent++;
   endtask

   // Check each response beat against the oldest prediction; randomise ready
   always @(posedge clock) begin
      probe_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result beat 0x%02h", rsp_tdata));
            end else begin
               want = pending_results.pop_front();
               status_seen[want.status]++;
               if (rsp_tdata[1:0] != want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_tdata[1:0], want.status));
               if (rsp_tdata[5:2] != want.slot)
                  report_mismatch($sformatf("slot %0d, expected %0d",
                                            rsp_tdata[5:2], want.slot));
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Empty table search, collisions, wraparound from the last slot, duplicates
   task automatic test_directed_probes();
      send_request(lpht_pkg::MODE_SEARCH, '0);
      send_request(lpht_pkg::MODE_INSERT, KEY_MAX);
      send_request(lpht_pkg::MODE_INSERT, lpht_pkg::KEY_W'(15));
      send_request(lpht_pkg::MODE_INSERT, '0);
      send_request(lpht_pkg::MODE_INSERT, KEY_MAX);
      send_request(lpht_pkg::MODE_SEARCH, KEY_MAX);
      send_request(lpht_pkg::MODE_SEARCH, '0);
      send_request(lpht_pkg::MODE_SEARCH, lpht_pkg::KEY_W'(15));
      send_request(lpht_pkg::MODE_SEARCH, lpht_pkg::KEY_W'(31));
      send_request(lpht_pkg::MODE_INSERT, lpht_pkg::KEY_W'(32'h5555_5555));
      send_request(lpht_pkg::MODE_SEARCH, lpht_pkg::KEY_W'(32'h2AAA_AAAA));
      send_request(lpht_pkg::MODE_INSERT, lpht_pkg::KEY_W'(32'h2AAA_AAAA));
      send_request(lpht_pkg::MODE_SEARCH, lpht_pkg::KEY_W'(32'h2AAA_AAAA));
      send_request(lpht_pkg::MODE_SEARCH, lpht_pkg::KEY_W'(32'h5555_5555));
   endtask

   // Top up the table, then an insert that must report full and a search that wraps
   task automatic test_table_full();
      logic [lpht_pkg::KEY_W-1:0] absent;
      while (model_used.sum() with (int'(item)) < lpht_pkg::TABLE_SIZE)
         send_request(lpht_pkg::MODE_INSERT,
                      lpht_pkg::KEY_W'(7 + lpht_pkg::TABLE_SIZE * $urandom_range(0, 3)));
      send_request(lpht_pkg::MODE_INSERT, lpht_pkg::KEY_W'($urandom()));
      do
         absent = lpht_pkg::KEY_W'($urandom());
      while (key_stored(absent));
      send_request(lpht_pkg::MODE_SEARCH, absent);
      send_request(lpht_pkg::MODE_SEARCH, lpht_pkg::KEY_W'(7));
   endtask

   // Mostly searches, many of them for keys drawn from the table; inserts are rarer so
   // the table fills slowly and probes see partial occupancy for a while
   task automatic test_random_mix(int count, int idle_pct, int stall_pct);
      lpht_pkg::mode_type         mode;
      logic [lpht_pkg::KEY_W-1:0] key;
      int                         pick;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) begin
         mode = ($urandom_range(15) == 0) ? lpht_pkg::MODE_INSERT : lpht_pkg::MODE_SEARCH;
         pick = $urandom_range(99);
         if (pick < 45)
            key = any_stored_key();
         else if (pick < 75)
            key = colliding_key();
         else if (pick < 80)
            key = ($urandom_range(1)) ? KEY_MAX : '0;
         else if (pick < 90)
            key = lpht_pkg::KEY_W'($urandom_range(63));
         else
            key = lpht_pkg::KEY_W'($urandom());
         send_request(mode, key);
      end
   endtask

   initial begin
      for (int i = 0; i < lpht_pkg::TABLE_SIZE; i++) begin
         model_used[i] = 1'b0;
         model_keys[i] = '0;
      end
      foreach (status_seen[i])
         status_seen[i] = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_probes();
      test_random_mix(400, 24, 50);
      test_table_full();
      test_random_mix(400, 50, 24);
      test_random_mix(400, 0, 0);

      // drop valid after the last beat and drain
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d inserts and %0d searches across three idle/stall mixes",
               inserts_sent, searches_sent);
      $display("Outcomes: %0d inserted, %0d full, %0d found, %0d not found",
               status_seen[lpht_pkg::ST_INSERTED], status_seen[lpht_pkg::ST_FULL],
               status_seen[lpht_pkg::ST_FOUND], status_seen[lpht_pkg::ST_NOT_FOUND]);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/lpht_pkg.sv
rtl/lpht_ctrl.sv
rtl/lpht_dp.sv
rtl/linear_probe_hash_table.sv
verif/tb.sv
